>>> hdl/tun_pkg.sv
// ----------------------------------------------------------------------------
// tun_pkg
// Shared widths, constants and stage payload types for the triangle normal unit.
// ----------------------------------------------------------------------------
package tun_pkg;

    localparam int COORD_BITS       = 16;
    localparam int NORMAL_FRAC_BITS = 14;
    localparam int NORMAL_BITS      = NORMAL_FRAC_BITS + 2;
    localparam int LANES            = 3;

    // edge differences, products and cross-product magnitudes
    localparam int DIFF_BITS = COORD_BITS + 1;
    localparam int PROD_BITS = 2 * DIFF_BITS;
    localparam int MAG_BITS  = PROD_BITS;
    localparam int HALF_BITS = MAG_BITS / 2;

    // squares, squared length and root search
    localparam int SQ_BITS   = 2 * MAG_BITS;
    localparam int SUM_BITS  = SQ_BITS + 2;
    localparam int ROOT_BITS = NORMAL_BITS;
    localparam int REM_BITS  = SUM_BITS + 2 * ROOT_BITS + 1;
    localparam int REM_SHIFT = 2 * NORMAL_FRAC_BITS + 2;

    // one triangle as it enters the pipe
    typedef struct packed {
        logic signed [COORD_BITS-1:0] ax;
        logic signed [COORD_BITS-1:0] ay;
        logic signed [COORD_BITS-1:0] az;
        logic signed [COORD_BITS-1:0] bx;
        logic signed [COORD_BITS-1:0] by;
        logic signed [COORD_BITS-1:0] bz;
        logic signed [COORD_BITS-1:0] cx;
        logic signed [COORD_BITS-1:0] cy;
        logic signed [COORD_BITS-1:0] cz;
    } vertex_t;

    // cross product as sign and magnitude
    typedef struct packed {
        logic [LANES-1:0]               neg;
        logic [LANES-1:0][MAG_BITS-1:0] mag;
    } cross_t;

    // running state of the bitwise root search, one lane per component
    typedef struct packed {
        logic [LANES-1:0]                neg;
        logic                            degen;
        logic [SUM_BITS-1:0]             s;
        logic [LANES-1:0][REM_BITS-1:0]  rem;
        logic [LANES-1:0][REM_BITS-1:0]  acc;
        logic [LANES-1:0][ROOT_BITS-1:0] root;
    } root_t;

endpackage

>>> hdl/tun_if.sv
// ----------------------------------------------------------------------------
// tun_if
// Valid/ready channel interfaces for triangle vertices and unit normals.
// ----------------------------------------------------------------------------
interface tun_vertex_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [tun_pkg::COORD_BITS-1:0]  ax;
    logic signed [tun_pkg::COORD_BITS-1:0]  ay;
    logic signed [tun_pkg::COORD_BITS-1:0]  az;
    logic signed [tun_pkg::COORD_BITS-1:0]  bx;
    logic signed [tun_pkg::COORD_BITS-1:0]  by;
    logic signed [tun_pkg::COORD_BITS-1:0]  bz;
    logic signed [tun_pkg::COORD_BITS-1:0]  cx;
    logic signed [tun_pkg::COORD_BITS-1:0]  cy;
    logic signed [tun_pkg::COORD_BITS-1:0]  cz;

    modport source (output valid, ax, ay, az, bx, by, bz, cx, cy, cz, input ready);
    modport sink   (input valid, ax, ay, az, bx, by, bz, cx, cy, cz, output ready);
endinterface

interface tun_normal_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [tun_pkg::NORMAL_BITS-1:0] normal_x;
    logic signed [tun_pkg::NORMAL_BITS-1:0] normal_y;
    logic signed [tun_pkg::NORMAL_BITS-1:0] normal_z;
    logic                                   degenerate;

    modport source (output valid, normal_x, normal_y, normal_z, degenerate, input ready);
    modport sink   (input valid, normal_x, normal_y, normal_z, degenerate, output ready);
endinterface

>>> hdl/tun_cross.sv
// ----------------------------------------------------------------------------
// tun_cross
// Three stages: edge vectors, partial products, cross product as sign/magnitude.
// ----------------------------------------------------------------------------
module tun_cross (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  tun_pkg::vertex_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output tun_pkg::cross_t  out_data
);

    logic [2:0] valid_reg;
    logic [3:0] ready;

    logic signed [tun_pkg::DIFF_BITS-1:0] u_reg [tun_pkg::LANES];
    logic signed [tun_pkg::DIFF_BITS-1:0] w_reg [tun_pkg::LANES];
    logic signed [tun_pkg::DIFF_BITS-1:0] u_next [tun_pkg::LANES];
    logic signed [tun_pkg::DIFF_BITS-1:0] w_next [tun_pkg::LANES];
    logic signed [tun_pkg::PROD_BITS-1:0] p_reg [6];
    logic signed [tun_pkg::PROD_BITS-1:0] p_next [6];
    logic signed [tun_pkg::PROD_BITS-1:0] n_next [tun_pkg::LANES];
    tun_pkg::cross_t cross_reg;
    tun_pkg::cross_t cross_next;

    // stall chain: a stage moves when empty or when the next one moves
    assign ready[3] = out_ready;
    assign ready[2] = !valid_reg[2] || ready[3];
    assign ready[1] = !valid_reg[1] || ready[2];
    assign ready[0] = !valid_reg[0] || ready[1];
    assign in_ready = ready[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (ready[0]) valid_reg[0] <= in_valid;
            if (ready[1]) valid_reg[1] <= valid_reg[0];
            if (ready[2]) valid_reg[2] <= valid_reg[1];
        end
    end

    // edge vectors U = C - B, W = A - B
    always_comb
    begin
        u_next[0] = tun_pkg::DIFF_BITS'(in_data.cx) - tun_pkg::DIFF_BITS'(in_data.bx);
        u_next[1] = tun_pkg::DIFF_BITS'(in_data.cy) - tun_pkg::DIFF_BITS'(in_data.by);
        u_next[2] = tun_pkg::DIFF_BITS'(in_data.cz) - tun_pkg::DIFF_BITS'(in_data.bz);
        w_next[0] = tun_pkg::DIFF_BITS'(in_data.ax) - tun_pkg::DIFF_BITS'(in_data.bx);
        w_next[1] = tun_pkg::DIFF_BITS'(in_data.ay) - tun_pkg::DIFF_BITS'(in_data.by);
        w_next[2] = tun_pkg::DIFF_BITS'(in_data.az) - tun_pkg::DIFF_BITS'(in_data.bz);
    end

    // six partial products of the cross product
    always_comb
    begin
        p_next[0] = tun_pkg::PROD_BITS'(u_reg[1]) * tun_pkg::PROD_BITS'(w_reg[2]);
        p_next[1] = tun_pkg::PROD_BITS'(u_reg[2]) * tun_pkg::PROD_BITS'(w_reg[1]);
        p_next[2] = tun_pkg::PROD_BITS'(u_reg[2]) * tun_pkg::PROD_BITS'(w_reg[0]);
        p_next[3] = tun_pkg::PROD_BITS'(u_reg[0]) * tun_pkg::PROD_BITS'(w_reg[2]);
        p_next[4] = tun_pkg::PROD_BITS'(u_reg[0]) * tun_pkg::PROD_BITS'(w_reg[1]);
        p_next[5] = tun_pkg::PROD_BITS'(u_reg[1]) * tun_pkg::PROD_BITS'(w_reg[0]);
    end

    // components and their sign/magnitude split
    always_comb
    begin
        n_next[0] = p_reg[0] - p_reg[1];
        n_next[1] = p_reg[2] - p_reg[3];
        n_next[2] = p_reg[4] - p_reg[5];
        for (int j = 0; j < tun_pkg::LANES; j++)
        begin
            cross_next.neg[j] = n_next[j][tun_pkg::PROD_BITS-1];
            cross_next.mag[j] = cross_next.neg[j] ? tun_pkg::MAG_BITS'(-n_next[j])
                                                  : tun_pkg::MAG_BITS'(n_next[j]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready[0] && in_valid)
        begin
            u_reg <= u_next;
            w_reg <= w_next;
        end
        if (ready[1] && valid_reg[0])
        begin
            p_reg <= p_next;
        end
        if (ready[2] && valid_reg[1])
        begin
            cross_reg <= cross_next;
        end
    end

    assign out_valid = valid_reg[2];
    assign out_data  = cross_reg;

endmodule

>>> hdl/tun_sumsq.sv
// ----------------------------------------------------------------------------
// tun_sumsq
// Three stages: split squares, square assembly, squared length and search seed.
// ----------------------------------------------------------------------------
module tun_sumsq (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  tun_pkg::cross_t in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output tun_pkg::root_t  out_data
);

    logic [2:0] valid_reg;
    logic [3:0] ready;

    logic [tun_pkg::MAG_BITS-1:0] hh_reg [tun_pkg::LANES];
    logic [tun_pkg::MAG_BITS-1:0] hl_reg [tun_pkg::LANES];
    logic [tun_pkg::MAG_BITS-1:0] ll_reg [tun_pkg::LANES];
    logic [tun_pkg::MAG_BITS-1:0] hh_next [tun_pkg::LANES];
    logic [tun_pkg::MAG_BITS-1:0] hl_next [tun_pkg::LANES];
    logic [tun_pkg::MAG_BITS-1:0] ll_next [tun_pkg::LANES];
    logic [tun_pkg::SQ_BITS-1:0]  sq_reg [tun_pkg::LANES];
    logic [tun_pkg::SQ_BITS-1:0]  sq_next [tun_pkg::LANES];
    logic [tun_pkg::LANES-1:0]    neg1_reg;
    logic [tun_pkg::LANES-1:0]    neg2_reg;
    logic [tun_pkg::SUM_BITS-1:0] sum_next;
    tun_pkg::root_t               seed_reg;
    tun_pkg::root_t               seed_next;

    assign ready[3] = out_ready;
    assign ready[2] = !valid_reg[2] || ready[3];
    assign ready[1] = !valid_reg[1] || ready[2];
    assign ready[0] = !valid_reg[0] || ready[1];
    assign in_ready = ready[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (ready[0]) valid_reg[0] <= in_valid;
            if (ready[1]) valid_reg[1] <= valid_reg[0];
            if (ready[2]) valid_reg[2] <= valid_reg[1];
        end
    end

    // half-width partial products of each square
    always_comb
    begin
        for (int j = 0; j < tun_pkg::LANES; j++)
        begin
            hh_next[j] = tun_pkg::MAG_BITS'(in_data.mag[j][tun_pkg::MAG_BITS-1:tun_pkg::HALF_BITS])
                       * tun_pkg::MAG_BITS'(in_data.mag[j][tun_pkg::MAG_BITS-1:tun_pkg::HALF_BITS]);
            hl_next[j] = tun_pkg::MAG_BITS'(in_data.mag[j][tun_pkg::MAG_BITS-1:tun_pkg::HALF_BITS])
                       * tun_pkg::MAG_BITS'(in_data.mag[j][tun_pkg::HALF_BITS-1:0]);
            ll_next[j] = tun_pkg::MAG_BITS'(in_data.mag[j][tun_pkg::HALF_BITS-1:0])
                       * tun_pkg::MAG_BITS'(in_data.mag[j][tun_pkg::HALF_BITS-1:0]);
        end
    end

    // c^2 = hh * 2^(2h) + 2 * hl * 2^h + ll
    always_comb
    begin
        for (int j = 0; j < tun_pkg::LANES; j++)
        begin
            sq_next[j] = (tun_pkg::SQ_BITS'(hh_reg[j]) << (2 * tun_pkg::HALF_BITS))
                       + (tun_pkg::SQ_BITS'(hl_reg[j]) << (tun_pkg::HALF_BITS + 1))
                       + tun_pkg::SQ_BITS'(ll_reg[j]);
        end
    end

    // squared length, zero test, root search seed
    always_comb
    begin
        sum_next = tun_pkg::SUM_BITS'(sq_reg[0]) + tun_pkg::SUM_BITS'(sq_reg[1])
                 + tun_pkg::SUM_BITS'(sq_reg[2]);
        seed_next.neg   = neg2_reg;
        seed_next.degen = (sum_next == '0);
        seed_next.s     = sum_next;
        for (int j = 0; j < tun_pkg::LANES; j++)
        begin
            seed_next.rem[j]  = tun_pkg::REM_BITS'(sq_reg[j]) << tun_pkg::REM_SHIFT;
            seed_next.acc[j]  = '0;
            seed_next.root[j] = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready[0] && in_valid)
        begin
            hh_reg   <= hh_next;
            hl_reg   <= hl_next;
            ll_reg   <= ll_next;
            neg1_reg <= in_data.neg;
        end
        if (ready[1] && valid_reg[0])
        begin
            sq_reg   <= sq_next;
            neg2_reg <= neg1_reg;
        end
        if (ready[2] && valid_reg[1])
        begin
            seed_reg <= seed_next;
        end
    end

    assign out_valid = valid_reg[2];
    assign out_data  = seed_reg;

endmodule

>>> hdl/tun_root.sv
// ----------------------------------------------------------------------------
// tun_root
// Bitwise search for m = floor(sqrt(c^2 * 2^(2F+2) / S)), one bit per stage.
// ----------------------------------------------------------------------------
module tun_root (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  tun_pkg::root_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output tun_pkg::root_t out_data
);

    logic [tun_pkg::ROOT_BITS-1:0] valid_reg;
    tun_pkg::root_t                data_reg [tun_pkg::ROOT_BITS];
    logic [tun_pkg::ROOT_BITS:0]   stage_valid;
    logic [tun_pkg::ROOT_BITS:0]   stage_ready;
    tun_pkg::root_t                stage_data [tun_pkg::ROOT_BITS+1];

    assign stage_valid[0]                  = in_valid;
    assign stage_data[0]                   = in_data;
    assign stage_ready[tun_pkg::ROOT_BITS] = out_ready;
    assign in_ready                        = stage_ready[0];

    for (genvar i = 0; i < tun_pkg::ROOT_BITS; i++)
    begin : g_step
        localparam int B = tun_pkg::ROOT_BITS - 1 - i;
        tun_pkg::root_t step_next;

        assign stage_valid[i+1] = valid_reg[i];
        assign stage_data[i+1]  = data_reg[i];
        assign stage_ready[i]   = !valid_reg[i] || stage_ready[i+1];

        // try bit B: (2m + 2^B) * 2^B * S against the remainder
        always_comb
        begin
            logic [tun_pkg::REM_BITS-1:0] dec;
            logic [tun_pkg::REM_BITS:0]   dif;
            step_next = stage_data[i];
            for (int j = 0; j < tun_pkg::LANES; j++)
            begin
                dec = (stage_data[i].acc[j] << (B + 1))
                    + (tun_pkg::REM_BITS'(stage_data[i].s) << (2 * B));
                dif = {1'b0, stage_data[i].rem[j]} - {1'b0, dec};
                if (!dif[tun_pkg::REM_BITS])
                begin
                    step_next.rem[j]     = dif[tun_pkg::REM_BITS-1:0];
                    step_next.acc[j]     = stage_data[i].acc[j]
                                         + (tun_pkg::REM_BITS'(stage_data[i].s) << B);
                    step_next.root[j][B] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else if (stage_ready[i])
            begin
                valid_reg[i] <= stage_valid[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (stage_ready[i] && stage_valid[i])
            begin
                data_reg[i] <= step_next;
            end
        end
    end

    assign out_valid = stage_valid[tun_pkg::ROOT_BITS];
    assign out_data  = stage_data[tun_pkg::ROOT_BITS];

endmodule

>>> hdl/triangle_unit_normal.sv
// Vertex to normal: cross stages, sum-of-squares stages, root stages, output register.
// Throughput: one triangle per cycle while not stalled; 16 root stages, one bit each.
// A stalled output holds the pipe; empty stages still fill behind it.
// Reset (rst_n, async, active low) clears all valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
// triangle_unit_normal
// Unit face normal of a triangle in Q2.14, with degenerate flag.
// ----------------------------------------------------------------------------
module triangle_unit_normal (
    input  logic         clk,
    input  logic         rst_n,
    tun_vertex_if.sink   vtx,
    tun_normal_if.source nrm
);

    tun_pkg::vertex_t vtx_data;
    tun_pkg::cross_t  cross_data;
    tun_pkg::root_t   seed_data;
    tun_pkg::root_t   root_data;
    logic             cross_valid, cross_ready;
    logic             seed_valid, seed_ready;
    logic             root_valid, root_ready;

    logic                                   out_valid_reg;
    logic signed [tun_pkg::NORMAL_BITS-1:0] nrm_reg [tun_pkg::LANES];
    logic signed [tun_pkg::NORMAL_BITS-1:0] nrm_next [tun_pkg::LANES];
    logic                                   degen_reg;
    logic [tun_pkg::ROOT_BITS:0]            half_up;

    assign vtx_data = '{ax: vtx.ax, ay: vtx.ay, az: vtx.az,
                        bx: vtx.bx, by: vtx.by, bz: vtx.bz,
                        cx: vtx.cx, cy: vtx.cy, cz: vtx.cz};

    tun_cross u_cross (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vtx.valid),
        .in_ready  (vtx.ready),
        .in_data   (vtx_data),
        .out_valid (cross_valid),
        .out_ready (cross_ready),
        .out_data  (cross_data)
    );

    tun_sumsq u_sumsq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cross_valid),
        .in_ready  (cross_ready),
        .in_data   (cross_data),
        .out_valid (seed_valid),
        .out_ready (seed_ready),
        .out_data  (seed_data)
    );

    tun_root u_root (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (seed_valid),
        .in_ready  (seed_ready),
        .in_data   (seed_data),
        .out_valid (root_valid),
        .out_ready (root_ready),
        .out_data  (root_data)
    );

    assign root_ready = !out_valid_reg || nrm.ready;

    // round: k = (m + 1) / 2, then restore sign; zero for a degenerate triangle
    always_comb
    begin
        half_up = '0;
        for (int j = 0; j < tun_pkg::LANES; j++)
        begin
            half_up = (tun_pkg::ROOT_BITS+1)'(root_data.root[j]) + 1'b1;
            if (root_data.degen)
            begin
                nrm_next[j] = '0;
            end
            else if (root_data.neg[j])
            begin
                nrm_next[j] = -tun_pkg::NORMAL_BITS'(half_up[tun_pkg::ROOT_BITS:1]);
            end
            else
            begin
                nrm_next[j] = tun_pkg::NORMAL_BITS'(half_up[tun_pkg::ROOT_BITS:1]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (root_ready)
        begin
            out_valid_reg <= root_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (root_ready && root_valid)
        begin
            nrm_reg   <= nrm_next;
            degen_reg <= root_data.degen;
        end
    end

    assign nrm.valid      = out_valid_reg;
    assign nrm.normal_x   = nrm_reg[0];
    assign nrm.normal_y   = nrm_reg[1];
    assign nrm.normal_z   = nrm_reg[2];
    assign nrm.degenerate = degen_reg;

endmodule

>>> hdl/tun_checker.sv
// ----------------------------------------------------------------------------
// tun_checker
// Port-level checks on the triangle normal unit, bound to the top level.
// ----------------------------------------------------------------------------
module tun_checker (
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   in_valid,
    input logic                                   in_ready,
    input logic                                   out_valid,
    input logic                                   out_ready,
    input logic signed [tun_pkg::NORMAL_BITS-1:0] normal_x,
    input logic signed [tun_pkg::NORMAL_BITS-1:0] normal_y,
    input logic signed [tun_pkg::NORMAL_BITS-1:0] normal_z,
    input logic                                   degenerate
);

    localparam logic signed [tun_pkg::NORMAL_BITS-1:0] ONE =
        tun_pkg::NORMAL_BITS'(1) << tun_pkg::NORMAL_FRAC_BITS;

    // a pending result stays until its transaction completes
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // input back-pressure only ever comes from a stalled output
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output stall");

    // degenerate triangles give a zero normal
    a_degen: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> normal_x == '0 && normal_y == '0 && normal_z == '0)
        else $error("degenerate result not zero");

    // every component is within unit range
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> normal_x <= ONE && normal_x >= -ONE && normal_y <= ONE
                   && normal_y >= -ONE && normal_z <= ONE && normal_z >= -ONE)
        else $error("normal component out of range");

endmodule

bind triangle_unit_normal tun_checker u_tun_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (vtx.valid),
    .in_ready   (vtx.ready),
    .out_valid  (nrm.valid),
    .out_ready  (nrm.ready),
    .normal_x   (nrm.normal_x),
    .normal_y   (nrm.normal_y),
    .normal_z   (nrm.normal_z),
    .degenerate (nrm.degenerate)
);

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the triangle unit normal: drives directed rows and random
// vertex bursts, stalls the normal channel on its own pattern, and checks every
// normal transaction against its listed result or an exact integer model of the
// cross product and its round-to-nearest reciprocal square-root scaling.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int N_RANDOM    = 1530;
    localparam int DRAIN_WAIT  = 40;

    typedef struct packed {
        logic signed [tun_pkg::NORMAL_BITS-1:0] x;
        logic signed [tun_pkg::NORMAL_BITS-1:0] y;
        logic signed [tun_pkg::NORMAL_BITS-1:0] z;
        logic                                   degen;
    } normal_t;

    typedef struct {
        tun_pkg::vertex_t v;
        bit               typed;
        normal_t          res;
    } stim_row_t;

    logic clk;
    logic rst_n;
    int   errors;
    int   cycle_cnt;

    tun_vertex_if vtx ();
    tun_normal_if nrm ();

    normal_t expected_normals[$];

    triangle_unit_normal dut (
        .clk   (clk),
        .rst_n (rst_n),
        .vtx   (vtx),
        .nrm   (nrm)
    );

    // clock, 2 ns period
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // exact face normal: cross product, squared length, rounded scaling
    function automatic normal_t face_normal(tun_pkg::vertex_t v);
        longint        ux, uy, uz, wx, wy, wz;
        longint        cr[3];
        logic [127:0]  len_sq, mag, rhs, lhs, odd;
        int unsigned   lo, hi, mid;
        logic signed [tun_pkg::NORMAL_BITS-1:0] comp[3];
        normal_t       r;
        ux = longint'(v.cx) - longint'(v.bx);
        uy = longint'(v.cy) - longint'(v.by);
        uz = longint'(v.cz) - longint'(v.bz);
        wx = longint'(v.ax) - longint'(v.bx);
        wy = longint'(v.ay) - longint'(v.by);
        wz = longint'(v.az) - longint'(v.bz);
        cr[0] = uy * wz - uz * wy;
        cr[1] = uz * wx - ux * wz;
        cr[2] = ux * wy - uy * wx;
        len_sq = '0;
        for (int i = 0; i < 3; i++)
        begin
            mag = (cr[i] < 0) ? 128'(-cr[i]) : 128'(cr[i]);
            len_sq += mag * mag;
        end
        if (len_sq == 0)
        begin
            r = '0;
            r.degen = 1'b1;
            return r;
        end
        for (int i = 0; i < 3; i++)
        begin
            mag = (cr[i] < 0) ? 128'(-cr[i]) : 128'(cr[i]);
            rhs = (mag * mag) << (2 * tun_pkg::NORMAL_FRAC_BITS + 2);
            lo  = 0;
            hi  = 1 << tun_pkg::NORMAL_FRAC_BITS;
            // largest k with (2k-1)^2 * S <= (2 c 2^F)^2
            while (lo < hi)
            begin
                mid = lo + (hi - lo + 1) / 2;
                odd = 128'(2 * mid - 1);
                lhs = len_sq * odd * odd;
                if (lhs <= rhs)
                    lo = mid;
                else
                    hi = mid - 1;
            end
            comp[i] = (cr[i] < 0) ? -tun_pkg::NORMAL_BITS'(lo) : tun_pkg::NORMAL_BITS'(lo);
        end
        r.x     = comp[0];
        r.y     = comp[1];
        r.z     = comp[2];
        r.degen = 1'b0;
        return r;
    endfunction

    task automatic report(string field, int got, int want);
        $display("ERROR %0t: %s got %0d expected %0d", $time, field, got, want);
        errors++;
    endtask

    function automatic logic signed [tun_pkg::COORD_BITS-1:0] extreme_coord();
        case ($urandom_range(0, 4))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'sh0000;
            3: return 16'shffff;
            default: return 16'sh0001;
        endcase
    endfunction

    function automatic tun_pkg::vertex_t random_triangle();
        tun_pkg::vertex_t v;
        int      dx, dy, dz, k;
        case ($urandom_range(0, 19))
            0, 1, 2:
            begin
                // small triangles near the origin
                v.ax = $signed(16'($urandom_range(0, 63))) - 16'sd32;
                v.ay = $signed(16'($urandom_range(0, 63))) - 16'sd32;
                v.az = $signed(16'($urandom_range(0, 63))) - 16'sd32;
                v.bx = $signed(16'($urandom_range(0, 63))) - 16'sd32;
                v.by = $signed(16'($urandom_range(0, 63))) - 16'sd32;
                v.bz = $signed(16'($urandom_range(0, 63))) - 16'sd32;
                v.cx = $signed(16'($urandom_range(0, 63))) - 16'sd32;
                v.cy = $signed(16'($urandom_range(0, 63))) - 16'sd32;
                v.cz = $signed(16'($urandom_range(0, 63))) - 16'sd32;
            end
            3, 4:
            begin
                // collinear or coincident vertices
                v.bx = $signed(16'($urandom_range(0, 16383))) - 16'sd8192;
                v.by = $signed(16'($urandom_range(0, 16383))) - 16'sd8192;
                v.bz = $signed(16'($urandom_range(0, 16383))) - 16'sd8192;
                dx = int'($urandom_range(0, 4000)) - 2000;
                dy = int'($urandom_range(0, 4000)) - 2000;
                dz = int'($urandom_range(0, 4000)) - 2000;
                k  = int'($urandom_range(0, 6)) - 3;
                v.ax = v.bx + 16'(dx);
                v.ay = v.by + 16'(dy);
                v.az = v.bz + 16'(dz);
                v.cx = v.bx + 16'(k * dx);
                v.cy = v.by + 16'(k * dy);
                v.cz = v.bz + 16'(k * dz);
            end
            5, 6:
            begin
                v.ax = extreme_coord(); v.ay = extreme_coord(); v.az = extreme_coord();
                v.bx = extreme_coord(); v.by = extreme_coord(); v.bz = extreme_coord();
                v.cx = extreme_coord(); v.cy = extreme_coord(); v.cz = extreme_coord();
            end
            default:
                v = tun_pkg::vertex_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
        endcase
        return v;
    endfunction

    // one vertex transaction; valid stays high if the caller sends again
    task automatic send(tun_pkg::vertex_t v, bit typed, normal_t res);
        vtx.valid = 1'b1;
        vtx.ax = v.ax; vtx.ay = v.ay; vtx.az = v.az;
        vtx.bx = v.bx; vtx.by = v.by; vtx.bz = v.bz;
        vtx.cx = v.cx; vtx.cy = v.cy; vtx.cz = v.cz;
        do
            @(posedge clk);
        while (!vtx.ready);
        expected_normals.push_back(typed ? res : face_normal(v));
        @(negedge clk);
    endtask

    task automatic idle(int cycles);
        vtx.valid = 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    // directed rows
    stim_row_t directed[$];

    task automatic add_row(tun_pkg::vertex_t v, bit typed, normal_t res);
        stim_row_t r;
        r.v = v; r.typed = typed; r.res = res;
        directed.push_back(r);
    endtask

    // stimulus
    initial
    begin
        int burst;
        vtx.valid = 1'b0;
        vtx.ax = '0; vtx.ay = '0; vtx.az = '0;
        vtx.bx = '0; vtx.by = '0; vtx.bz = '0;
        vtx.cx = '0; vtx.cy = '0; vtx.cz = '0;
        rst_n  = 1'b0;
        errors = 0;

        // all zero, all max, all min: degenerate
        add_row('0, 1, '{x: 0, y: 0, z: 0, degen: 1});
        add_row({9{16'sh7fff}}, 1, '{x: 0, y: 0, z: 0, degen: 1});
        add_row({9{16'sh8000}}, 1, '{x: 0, y: 0, z: 0, degen: 1});
        // axis-aligned unit triangles
        add_row('{ax: 16'sd4096, default: 0}, 0, '0);
        add_row('{ax: 16'sd4096, cy: 16'sd4096, default: 0}, 1,
                '{x: 0, y: 0, z: -16384, degen: 0});
        add_row('{ay: 16'sd4096, cx: 16'sd4096, default: 0}, 1,
                '{x: 0, y: 0, z: 16384, degen: 0});
        add_row('{ay: 16'sd4096, cz: 16'sd4096, default: 0}, 1,
                '{x: -16384, y: 0, z: 0, degen: 0});
        add_row('{az: 16'sd4096, cx: 16'sd4096, default: 0}, 1,
                '{x: 0, y: -16384, z: 0, degen: 0});
        // collinear
        add_row('{ax: 16'sd1, ay: 16'sd2, az: 16'sd3, cx: -16'sd2, cy: -16'sd4,
                  cz: -16'sd6, default: 0}, 1, '{x: 0, y: 0, z: 0, degen: 1});
        // extreme spans and mixed signs
        add_row('{ax: 16'sh7fff, ay: 16'sh8000, az: 16'sh7fff, bx: 16'sh8000,
                  by: 16'sh7fff, bz: 16'sh8000, cx: 16'sh8000, cy: 16'sh8000,
                  cz: 16'sh7fff}, 0, '0);
        add_row('{ax: 16'sh7fff, by: 16'sh8000, cz: 16'sh7fff, default: 0}, 0, '0);
        add_row('{ax: 16'sh8000, ay: 16'sh8000, bx: 16'sh7fff, cy: 16'sh7fff,
                  cz: 16'sh8000, default: 0}, 0, '0);
        add_row('{ax: 16'sh7fff, ay: 16'sh7fff, az: 16'sh7fff, bx: 16'sh8000,
                  by: 16'sh8000, bz: 16'sh8000, cx: 16'sh7fff, cy: 16'sh8000,
                  cz: 16'sh7fff}, 0, '0);
        add_row('{ax: 16'sd1, cy: 16'sd1, default: 0}, 0, '0);
        add_row('{ax: 16'sd3, ay: 16'sd1, cx: 16'sd1, cy: 16'sd2, cz: 16'sd5,
                  default: 0}, 0, '0);
        add_row('{ax: -16'sd1, ay: -16'sd1, az: -16'sd1, cx: 16'sd1, default: 0}, 0, '0);
        add_row({16'shffff, 16'sh5555, 16'shaaaa, 16'sh1234, 16'shedcb,
                 16'sh0f0f, 16'shf0f0, 16'sh7ffe, 16'sh8001}, 0, '0);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed[i])
            send(directed[i].v, directed[i].typed, directed[i].res);

        // hold off until the pipe is empty
        vtx.valid = 1'b0;
        wait (expected_normals.size() == 0);
        @(negedge clk);

        // random part: bursts and gaps
        for (int n = 0; n < N_RANDOM; )
        begin
            burst = $urandom_range(1, 40);
            for (int b = 0; b < burst && n < N_RANDOM; b++, n++)
                send(random_triangle(), 0, '0);
            if ($urandom_range(0, 3) != 0)
                idle($urandom_range(1, 12));
        end
        vtx.valid = 1'b0;

        wait (expected_normals.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // receiver stall pattern: always ready, periodic, or random, per window
    initial
    begin
        int mode;
        nrm.ready = 1'b0;
        cycle_cnt = 0;
        forever
        begin
            @(negedge clk);
            cycle_cnt++;
            if (cycle_cnt % 256 == 0)
                mode = $urandom_range(0, 3);
            case (mode)
                0: nrm.ready = 1'b1;
                1: nrm.ready = (cycle_cnt % 5) < 3;
                2: nrm.ready = ($urandom_range(0, 3) != 0);
                default: nrm.ready = ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // compare each normal transaction with the oldest expectation
    always @(posedge clk)
    begin
        normal_t want;
        if (rst_n && nrm.valid && nrm.ready)
        begin
            if (expected_normals.size() == 0)
            begin
                $display("ERROR %0t: unexpected normal transaction", $time);
                errors++;
            end
            else
            begin
                want = expected_normals.pop_front();
                if (nrm.normal_x !== want.x)
                    report("normal_x", nrm.normal_x, want.x);
                if (nrm.normal_y !== want.y)
                    report("normal_y", nrm.normal_y, want.y);
                if (nrm.normal_z !== want.z)
                    report("normal_z", nrm.normal_z, want.z);
                if (nrm.degenerate !== want.degen)
                    report("degenerate", nrm.degenerate, want.degen);
            end
        end
    end

    // watchdog
    initial
    begin
        #400000;
        $display("Verification failed");
        $finish;
    end
endmodule

>>> sim.f
hdl/tun_pkg.sv
hdl/tun_if.sv
hdl/tun_cross.sv
hdl/tun_sumsq.sv
hdl/tun_root.sv
hdl/triangle_unit_normal.sv
hdl/tun_checker.sv
test/tb_top.sv
